@@ rtl/core/sha512_block_compression_unit_defines.svh @@
// assertion macros for the sha512 block compression unit
`ifndef SHA512_BLOCK_COMPRESSION_UNIT_DEFINES_SVH
`define SHA512_BLOCK_COMPRESSION_UNIT_DEFINES_SVH

// property that holds whenever reset is low
`define SBC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked also during reset
`define SBC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// types, constants and round functions of the sha512 block compression unit
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int WORD_W       = 64;
   localparam int BLOCK_WORDS  = 16;
   localparam int STATE_WORDS  = 8;
   localparam int ROUNDS       = 80;
   localparam int QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic [63:0] message_word;
      logic        new_message;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   // one entry of the queue between front and back
   typedef struct packed {
      logic       reload;
      logic [3:0] slot;
   } job_type;

   typedef enum logic [1:0] {
      BE_IDLE,
      BE_ROUND,
      BE_ADD,
      BE_EMIT
   } be_state_type;

   localparam logic [63:0] INIT_VALUES [STATE_WORDS] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] ROUND_K [ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] a);
      big_sigma0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] e);
      big_sigma1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

@@ rtl/core/sbc_front.sv @@
// ----------------------------------------------------------------------------
// sbc_front
// takes message words, writes them to the block buffer, queues a job per block
// ----------------------------------------------------------------------------
module sbc_front import sbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            queue_full,
   input  logic            buf_busy,
   output logic            wr_en,
   output logic [4:0]      wr_addr,
   output logic [63:0]     wr_data,
   output logic            job_push,
   output job_type         job
);

   logic [3:0] pos_ff, pos_in;
   logic       bank_ff, bank_in;
   logic       reload_ff, reload_in;
   logic [3:0] cur_pos;
   logic       accept;

   // two block banks: the back reads one while the front fills the other
   assign req_ready = !queue_full && !buf_busy;
   assign accept    = req_valid && req_ready;
   assign cur_pos   = req_payload.new_message ? 4'd0 : pos_ff;
   assign wr_en     = accept;
   assign wr_addr   = {bank_ff, cur_pos};
   assign wr_data   = req_payload.message_word;
   assign job_push  = accept && (cur_pos == 4'd15);
   assign job.reload = reload_ff || req_payload.new_message;
   assign job.slot   = {3'd0, bank_ff};

   always_comb begin
      pos_in    = pos_ff;
      bank_in   = bank_ff;
      reload_in = reload_ff;
      if (accept) begin
         pos_in    = cur_pos + 4'd1;
         reload_in = reload_ff || req_payload.new_message;
         if (cur_pos == 4'd15) begin
            bank_in   = !bank_ff;
            reload_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         bank_ff   <= 1'b0;
         reload_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         bank_ff   <= bank_in;
         reload_ff <= reload_in;
      end
   end

endmodule

@@ rtl/core/sbc_queue.sv @@
// ----------------------------------------------------------------------------
// sbc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module sbc_queue import sbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head,
   output logic [1:0] count
);

   job_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rp_ff];
   assign count     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

@@ rtl/core/sbc_back.sv @@
// ----------------------------------------------------------------------------
// sbc_back
// runs 80 rounds a job, updates chaining state and emits eight words
// ----------------------------------------------------------------------------
module sbc_back import sbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   input  job_type         job,
   output logic            job_pop,
   output logic            bank_busy,
   input  logic            wr_en,
   input  logic [4:0]      wr_addr,
   input  logic [63:0]     wr_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [63:0]  buf_ff [2*BLOCK_WORDS];
   logic [63:0]  rd_ff;
   logic [4:0]   rd_addr;
   logic [63:0]  w_ff  [BLOCK_WORDS];
   logic [63:0]  w_in  [BLOCK_WORDS];
   logic [63:0]  v_ff  [STATE_WORDS];
   logic [63:0]  v_in  [STATE_WORDS];
   logic [63:0]  h_ff  [STATE_WORDS];
   logic [63:0]  h_in  [STATE_WORDS];
   logic [6:0]   rnd_ff, rnd_in;
   logic [3:0]   idx_ff, idx_in;
   logic         bank_ff, bank_in;
   be_state_type state_ff, state_in;
   logic         ov_ff, ov_in;
   rsp_payload_type o_ff, o_in;
   logic [63:0]  wt, wnew, t1, t2;

   // block memory: one write port from the front, one read port here
   assign rd_addr = {bank_ff, rnd_ff[3:0]};
   always_ff @(posedge clock) begin
      if (wr_en) buf_ff[wr_addr] <= wr_data;
      rd_ff <= buf_ff[rd_addr];
   end

   // the bank in use stays busy until its rounds are done reading it
   assign bank_busy = (state_ff == BE_ROUND) && (rnd_ff < 7'd17) && (wr_addr[4] == bank_ff);

   assign wnew = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);
   assign wt   = (rnd_ff < 7'd17) ? rd_ff : wnew;
   assign t1   = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
                 + ROUND_K[rnd_ff - 7'd1] + wt;
   assign t2   = big_sigma0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
                 ^ (v_ff[1] & v_ff[2]));
   assign rsp_valid   = ov_ff;
   assign rsp_payload = o_ff;

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      bank_in  = bank_ff;
      ov_in    = ov_ff;
      o_in     = o_ff;
      w_in     = w_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      job_pop  = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               bank_in  = job.slot[0];
               rnd_in   = 7'd0;
               if (job.reload) begin
                  h_in = INIT_VALUES;
                  v_in = INIT_VALUES;
               end else begin
                  v_in = h_ff;
               end
               state_in = BE_ROUND;
            end
         end
         BE_ROUND: begin
            // count 0 only primes the read port; rounds run on counts 1..80
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff != 7'd0) begin
               for (int i = 0; i < BLOCK_WORDS - 1; i++) w_in[i] = w_ff[i+1];
               w_in[BLOCK_WORDS-1] = wt;
               for (int i = 1; i < STATE_WORDS; i++) v_in[i] = v_ff[i-1];
               v_in[4] = v_ff[3] + t1;
               v_in[0] = t1 + t2;
               if (rnd_ff == 7'(ROUNDS)) state_in = BE_ADD;
            end
         end
         BE_ADD: begin
            for (int i = 0; i < STATE_WORDS; i++) h_in[i] = h_ff[i] + v_ff[i];
            idx_in   = '0;
            state_in = BE_EMIT;
         end
         BE_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               o_in.digest_word = h_ff[idx_ff[2:0]];
               o_in.word_index  = idx_ff[2:0];
               o_in.last_word   = (idx_ff == 4'd7);
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd7) state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      v_ff  <= v_in;
      o_ff  <= o_in;
      idx_ff <= idx_in;
      bank_ff <= bank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         rnd_ff   <= '0;
         ov_ff    <= 1'b0;
         h_ff     <= INIT_VALUES;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         ov_ff    <= ov_in;
         h_ff     <= h_in;
      end
   end

endmodule

@@ rtl/core/sha512_block_compression_unit.sv @@
// ----------------------------------------------------------------------------
// sha512_block_compression_unit
// sha-512 compression of 16-word blocks with chaining state kept inside
// ----------------------------------------------------------------------------
//  channel  dir  payload           transaction
//  req_     in   req_payload_type  one 64-bit message word
//  rsp_     out  rsp_payload_type  one updated chaining word, eight per block
//
// a block in the round unit goes through a read-port prime, then 80 rounds
// at one per cycle, a chaining add, then eight output transactions
// the front keeps taking words into a second buffer bank while a block runs
// reset clears control and reloads the initial chaining values
// a stalled rsp_ side holds the round unit; the front stops when the queue fills
`include "sha512_block_compression_unit_defines.svh"

module sha512_block_compression_unit import sbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic        queue_full, queue_ne, job_push, job_pop, bank_busy, wr_en;
   logic [4:0]  wr_addr;
   logic [63:0] wr_data;
   logic [1:0]  queue_count;
   job_type     push_job, head_job;

   // front: word position, bank select, new_message handling
   sbc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .queue_full, .buf_busy(bank_busy), .wr_en, .wr_addr, .wr_data,
      .job_push, .job(push_job)
   );

   // queue of finished blocks waiting for the round unit
   sbc_queue u_queue (
      .clock, .reset, .push(job_push), .push_job, .full(queue_full),
      .pop(job_pop), .not_empty(queue_ne), .head(head_job), .count(queue_count)
   );

   // back: rounds, chaining add, output register
   sbc_back u_back (
      .clock, .reset, .job_valid(queue_ne), .job(head_job), .job_pop, .bank_busy,
      .wr_en, .wr_addr, .wr_data, .rsp_valid, .rsp_ready, .rsp_payload
   );

   `SBC_ASSERT(a_no_push_full, clock, reset, !(job_push && queue_full), "push into full queue")
   `SBC_ASSERT(a_pop_nonempty, clock, reset, job_pop |-> queue_ne, "pop from empty queue")
   `SBC_ASSERT(a_count_range, clock, reset, queue_count <= 2'(QUEUE_DEPTH), "queue overflow")
   `SBC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "output after reset")

endmodule
